### rtl/minmax_affine_quantizer_top_macros.svh
// Assertion macros shared by the checker.
`ifndef MINMAX_AFFINE_QUANTIZER_TOP_MACROS_SVH
`define MINMAX_AFFINE_QUANTIZER_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define MAQ_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/maq_pkg.sv
package maq_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int QCNT_W   = $clog2(QDEPTH + 1);

   // Scale factors: 2*255 for the unsigned code, 2*127*256 for the Q8.8 code.
   localparam logic [15:0] K_ASYM   = 16'd510;
   localparam logic [15:0] K_SYM    = 16'd65024;
   localparam logic [15:0] SPAN_ONE = 16'd256;

   typedef struct packed {
      logic signed [15:0] sample;
      logic signed [15:0] low_value;
      logic [15:0]        span;
      logic               overflowed;
      logic               final_res;
      logic               sym_mode;
   } q_entry_type;

endpackage

### rtl/maq_front.sv
module maq_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [15:0]         req_sample,
   input  logic                       req_last,
   input  logic                       sym_mode,
   input  logic [maq_pkg::QCNT_W-1:0] q_count,
   output logic                       busy,
   output logic                       q_push,
   output maq_pkg::q_entry_type       q_data
);
   import maq_pkg::*;

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_SPAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic signed [15:0] min_ff, min_in, max_ff, max_in;
   logic               drop_ff, drop_in;
   logic [15:0]        span_ff, span_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               issue_done_ff, issue_done_in;
   logic               rd_vld_ff, rd_fin_ff;
   logic signed [15:0] rd_data_ff;
   logic signed [15:0] store_mem [CAPACITY];

   logic               accept, store_ok, issue, at_last;
   logic [IDX_W-1:0]   idx_last;
   logic [QCNT_W:0]    occupancy;
   logic [16:0]        abs_min, abs_max, diff;
   logic [15:0]        span_raw;

   assign accept    = start && (state_ff == ST_LOAD);
   assign store_ok  = (count_ff != CNT_W'(CAPACITY));
   assign idx_last  = IDX_W'(count_ff - CNT_W'(1));
   assign occupancy = {1'b0, q_count} + (QCNT_W + 1)'(rd_vld_ff);
   assign issue     = (state_ff == ST_DRAIN) && !issue_done_ff
                      && (occupancy < (QCNT_W + 1)'(QDEPTH));
   assign at_last   = (rd_idx_ff == idx_last);
   assign busy      = (state_ff != ST_LOAD);

   assign abs_min  = min_ff[15] ? 17'(-{min_ff[15], min_ff}) : 17'({min_ff[15], min_ff});
   assign abs_max  = max_ff[15] ? 17'(-{max_ff[15], max_ff}) : 17'({max_ff[15], max_ff});
   assign diff     = 17'({max_ff[15], max_ff} - {min_ff[15], min_ff});
   assign span_raw = sym_mode ? ((abs_min > abs_max) ? abs_min[15:0] : abs_max[15:0])
                              : diff[15:0];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      drop_in       = drop_ff;
      span_in       = span_ff;
      rd_idx_in     = rd_idx_ff;
      issue_done_in = issue_done_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (store_ok) begin
                  if (count_ff == '0) begin
                     min_in = req_sample;
                     max_in = req_sample;
                  end else begin
                     if (req_sample < min_ff) min_in = req_sample;
                     if (req_sample > max_ff) max_in = req_sample;
                  end
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_last) state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            span_in  = (span_raw == '0) ? SPAN_ONE : span_raw;
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (issue) begin
               rd_idx_in = rd_idx_ff + IDX_W'(1);
               if (at_last) issue_done_in = 1'b1;
            end
            // Clear the tensor once its final sample enters the queue.
            if (rd_vld_ff && rd_fin_ff) begin
               state_in      = ST_LOAD;
               count_in      = '0;
               min_in        = '0;
               max_in        = '0;
               drop_in       = 1'b0;
               rd_idx_in     = '0;
               issue_done_in = 1'b0;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         min_ff        <= '0;
         max_ff        <= '0;
         drop_ff       <= 1'b0;
         rd_idx_ff     <= '0;
         issue_done_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rd_fin_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         drop_ff       <= drop_in;
         rd_idx_ff     <= rd_idx_in;
         issue_done_ff <= issue_done_in;
         rd_vld_ff     <= issue;
         rd_fin_ff     <= issue && at_last;
      end
   end

   always_ff @(posedge clock) begin
      span_ff <= span_in;
   end

   always_ff @(posedge clock) begin
      if (accept && store_ok) store_mem[count_ff[IDX_W-1:0]] <= req_sample;
      if (issue) rd_data_ff <= store_mem[rd_idx_ff];
   end

   assign q_push            = rd_vld_ff;
   assign q_data.sample     = rd_data_ff;
   assign q_data.low_value  = min_ff;
   assign q_data.span       = span_ff;
   assign q_data.overflowed = drop_ff;
   assign q_data.final_res  = rd_fin_ff;
   assign q_data.sym_mode   = sym_mode;

endmodule

### rtl/maq_queue.sv
module maq_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  maq_pkg::q_entry_type       push_data,
   input  logic                       pop,
   output maq_pkg::q_entry_type       pop_data,
   output logic [maq_pkg::QCNT_W-1:0] count
);
   import maq_pkg::*;

   q_entry_type         entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   assign pop_data = entry_ff[rd_ptr_ff];
   assign count    = count_ff;

endmodule

### rtl/maq_back.sv
module maq_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  maq_pkg::q_entry_type q_data,
   output logic                 q_pop,
   output logic                 rsp_valid,
   output logic signed [15:0]   rsp_quantized,
   output logic signed [15:0]   rsp_low_value,
   output logic [15:0]          rsp_span,
   output logic                 rsp_overflowed,
   output logic                 rsp_final_res
);
   import maq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;

   logic [1:0]         state_ff;
   logic [15:0]        op_ff;
   logic               neg_ff, mode_ff, ovf_ff, fin_ff;
   logic signed [15:0] low_ff;
   logic [15:0]        span_ff;
   logic [16:0]        rem_ff;
   logic [15:0]        low_bits_ff;
   logic [15:0]        quo_ff;
   logic [3:0]         step_ff;
   logic               valid_ff;
   logic signed [15:0] quant_ff;

   logic [16:0] diff, mag;
   logic [31:0] prod_sum;
   logic [17:0] trial, den;
   logic        ge;
   logic [15:0] quo_in;

   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign diff     = 17'({q_data.sample[15], q_data.sample}
                         - {q_data.low_value[15], q_data.low_value});
   assign mag      = q_data.sample[15] ? 17'(-{q_data.sample[15], q_data.sample})
                                       : 17'({q_data.sample[15], q_data.sample});
   assign prod_sum = op_ff * (mode_ff ? K_SYM : K_ASYM) + 32'(span_ff);
   assign den      = {1'b0, span_ff, 1'b0};
   assign trial    = {rem_ff, low_bits_ff[15]};
   assign ge       = (trial >= den);
   assign quo_in   = {quo_ff[14:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (q_valid) state_ff <= ST_MUL;
            ST_MUL:  state_ff <= ST_DIV;
            ST_DIV: begin
               if (step_ff == 4'd15) begin
                  state_ff <= ST_IDLE;
                  valid_ff <= 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               mode_ff <= q_data.sym_mode;
               op_ff   <= q_data.sym_mode ? mag[15:0] : diff[15:0];
               neg_ff  <= q_data.sym_mode && q_data.sample[15];
               low_ff  <= q_data.low_value;
               span_ff <= q_data.span;
               ovf_ff  <= q_data.overflowed;
               fin_ff  <= q_data.final_res;
            end
         end
         ST_MUL: begin
            // The quotient fits in 16 bits, so the upper half starts below the divisor.
            rem_ff      <= {1'b0, prod_sum[31:16]};
            low_bits_ff <= prod_sum[15:0];
            quo_ff      <= '0;
            step_ff     <= '0;
         end
         ST_DIV: begin
            rem_ff      <= ge ? 17'(trial - den) : trial[16:0];
            low_bits_ff <= {low_bits_ff[14:0], 1'b0};
            quo_ff      <= quo_in;
            step_ff     <= step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               quant_ff <= neg_ff ? 16'(-quo_in) : quo_in;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid      = valid_ff;
   assign rsp_quantized  = quant_ff;
   assign rsp_low_value  = low_ff;
   assign rsp_span       = span_ff;
   assign rsp_overflowed = ovf_ff;
   assign rsp_final_res  = fin_ff;

endmodule

### rtl/minmax_affine_quantizer_top.sv
// Load: one sample per cycle while busy is low; busy rises for the emission of a tensor.
// Emission: after the last sample, results are paced by the 16-step restoring divider
// in the back end, which takes a new sample only after finishing the one before.
// Results are single-cycle strobes; the receiver cannot stall them.
// Reset (synchronous, active high) clears the tensor state and the mode register.
module minmax_affine_quantizer_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_sample,
   input  logic               req_last,
   input  logic               csr_write_enable,
   input  logic               csr_write_data,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_quantized,
   output logic signed [15:0] rsp_low_value,
   output logic [15:0]        rsp_span,
   output logic               rsp_overflowed,
   output logic               rsp_final_res
);
   import maq_pkg::*;

   // Mode register: 0 selects the unsigned 8-bit code, 1 the symmetric Q8.8 code.
   logic sym_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         sym_mode_ff <= csr_write_data;
      end
   end

   q_entry_type           push_data, pop_data;
   logic                  push, pop;
   logic [QCNT_W-1:0]     q_count;

   // Front: store samples, track min/max, then stream the stored samples
   // with the tensor context into the queue.
   maq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_sample (req_sample),
      .req_last   (req_last),
      .sym_mode   (sym_mode_ff),
      .q_count    (q_count),
      .busy       (busy),
      .q_push     (push),
      .q_data     (push_data)
   );

   // Queue: decouple the read-out of the store from the divider.
   maq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .count     (q_count)
   );

   // Back: scale, divide by twice the span with rounding, and transfer a result.
   maq_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_count != '0),
      .q_data         (pop_data),
      .q_pop          (pop),
      .rsp_valid      (rsp_valid),
      .rsp_quantized  (rsp_quantized),
      .rsp_low_value  (rsp_low_value),
      .rsp_span       (rsp_span),
      .rsp_overflowed (rsp_overflowed),
      .rsp_final_res  (rsp_final_res)
   );

endmodule

### rtl/maq_checker.sv
`include "minmax_affine_quantizer_top_macros.svh"

module maq_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_last,
   input logic        rsp_valid,
   input logic [15:0] rsp_span
);

   `MAQ_ASSERT_SAME(a_span_nonzero, rsp_valid, rsp_span != 16'd0, "zero span on a result")
   `MAQ_ASSERT_NEXT(a_strobe_single, rsp_valid, !rsp_valid, "result strobes back to back")
   `MAQ_ASSERT_NEXT(a_last_busy, start && !busy && req_last, busy,
      "no emission after the last sample")

endmodule

bind minmax_affine_quantizer_top maq_checker u_maq_checker (.*);

### dv/tb_minmax_affine_quantizer_top.sv
module tb_minmax_affine_quantizer_top;
   import maq_pkg::*;

   typedef struct {
      logic signed [15:0] quantized;
      logic signed [15:0] low_value;
      logic [15:0]        span;
      logic               overflowed;
      logic               final_res;
   } quant_result_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [15:0] req_sample;
   logic               req_last;
   logic               csr_write_enable;
   logic               csr_write_data;
   logic               rsp_valid;
   logic signed [15:0] rsp_quantized;
   logic signed [15:0] rsp_low_value;
   logic [15:0]        rsp_span;
   logic               rsp_overflowed;
   logic               rsp_final_res;

   // Shadow copy of the tensor state and the mode register.
   logic               sym_mode_q;
   logic signed [15:0] tensor_store[CAPACITY];
   int unsigned        tensor_count;
   logic signed [15:0] tensor_min;
   logic signed [15:0] tensor_max;
   logic               tensor_dropped;

   quant_result_type   pending_codes[$];
   int unsigned        mismatch_count;
   bit                 quiet_phase;

   minmax_affine_quantizer_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample       (req_sample),
      .req_last         (req_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_quantized    (rsp_quantized),
      .rsp_low_value    (rsp_low_value),
      .rsp_span         (rsp_span),
      .rsp_overflowed   (rsp_overflowed),
      .rsp_final_res    (rsp_final_res)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Fold one accepted sample into the shadow tensor; on last, queue the
   // codes for every stored sample and clear the tensor.
   task automatic model_sample(input logic signed [15:0] x, input logic last);
      longint           span_v;
      longint           mag;
      longint           code;
      longint           diff;
      quant_result_type r;
      if (tensor_count < CAPACITY) begin
         if (tensor_count == 0) begin
            tensor_min = x;
            tensor_max = x;
         end else begin
            if (x < tensor_min) tensor_min = x;
            if (x > tensor_max) tensor_max = x;
         end
         tensor_store[tensor_count] = x;
         tensor_count++;
      end else begin
         tensor_dropped = 1'b1;
      end
      if (!last) return;
      if (sym_mode_q) begin
         span_v = (tensor_min < 0) ? -longint'(tensor_min) : longint'(tensor_min);
         mag    = (tensor_max < 0) ? -longint'(tensor_max) : longint'(tensor_max);
         if (mag > span_v) span_v = mag;
      end else begin
         span_v = longint'(tensor_max) - longint'(tensor_min);
      end
      if (span_v == 0) span_v = 256;
      for (int i = 0; i < tensor_count; i++) begin
         if (sym_mode_q) begin
            mag  = (tensor_store[i] < 0) ? -longint'(tensor_store[i])
                                         : longint'(tensor_store[i]);
            code = (2 * mag * 127 * 256 + span_v) / (2 * span_v);
            if (tensor_store[i] < 0) code = -code;
         end else begin
            diff = longint'(tensor_store[i]) - longint'(tensor_min);
            code = (diff * 510 + span_v) / (2 * span_v);
            if (code > 255) code = 255;
         end
         r.quantized  = code[15:0];
         r.low_value  = tensor_min;
         r.span       = span_v[15:0];
         r.overflowed = tensor_dropped;
         r.final_res  = (i + 1 == tensor_count);
         pending_codes.push_back(r);
      end
      tensor_count   = 0;
      tensor_min     = 0;
      tensor_max     = 0;
      tensor_dropped = 1'b0;
   endtask

   // Transfer one sample; hold start until busy is low at a rising edge.
   // Start stays high afterwards so the next sample can follow directly.
   task automatic send_sample(input logic signed [15:0] x, input logic last);
      if (!quiet_phase && $urandom_range(99) < 6) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      start      <= 1'b1;
      req_sample <= x;
      req_last   <= last;
      do @(posedge clock); while (busy);
      model_sample(x, last);
      @(negedge clock);
   endtask

   // Drain: drop start, wait for every queued code, then let the back end settle.
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_codes.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_mode(input logic mode);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sym_mode_q = mode;
   endtask

   task automatic send_tensor(input int len, input bit wide);
      logic signed [15:0] x;
      for (int i = 0; i < len; i++) begin
         x = wide ? 16'($urandom) : 16'($signed($urandom_range(0, 2000)) - 1000);
         send_sample(x, i == len - 1);
      end
   endtask

   // Extremes, zero span, and single-element tensors.
   task automatic test_directed_edges();
      send_sample(16'sh7FFF, 1'b0);
      send_sample(-16'sh8000, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'shAAAA, 1'b0);
      send_sample(16'sh5555, 1'b1);
      send_sample(16'sh0100, 1'b1);
      send_sample(-16'sh8000, 1'b1);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'sh0000, 1'b1);
   endtask

   task automatic test_store_overflow();
      for (int i = 0; i < CAPACITY; i++)
         send_sample(16'($urandom), 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(-16'sh8000, 1'b1);
   endtask

   // Mostly short tensors with random lengths, a few long; about half use wide samples.
   task automatic test_random_tensors(input int budget);
      int len;
      while (budget > 0) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(1, CAPACITY + 3)
                                        : $urandom_range(1, 8);
         if (len > budget) len = budget;
         send_tensor(len, 1'($urandom_range(1)));
         budget -= len;
      end
   endtask

   // Check each result strobe against the oldest queued code.
   always @(posedge clock) begin
      quant_result_type e;
      if (!reset && rsp_valid) begin
         if (pending_codes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result q=%0d low=%0d span=%0d",
                        rsp_quantized, rsp_low_value, rsp_span);
         end else begin
            e = pending_codes.pop_front();
            if (rsp_quantized !== e.quantized || rsp_low_value !== e.low_value ||
                rsp_span !== e.span || rsp_overflowed !== e.overflowed ||
                rsp_final_res !== e.final_res) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch exp q=%0d low=%0d span=%0d ovf=%b fin=%b",
                           e.quantized, e.low_value, e.span, e.overflowed,
                           e.final_res);
                  $display("         got q=%0d low=%0d span=%0d ovf=%b fin=%b",
                           rsp_quantized, rsp_low_value, rsp_span, rsp_overflowed,
                           rsp_final_res);
               end
            end
         end
      end
   end

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_sample       = '0;
      req_last         = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      sym_mode_q       = 1'b0;
      tensor_count     = 0;
      tensor_min       = 0;
      tensor_max       = 0;
      tensor_dropped   = 1'b0;
      mismatch_count   = 0;
      quiet_phase      = 1'b0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_directed_edges();
      write_mode(1'b1);
      test_directed_edges();
      // Run one stretch with no sender gaps at all.
      quiet_phase = 1'b1;
      test_store_overflow();
      quiet_phase = 1'b0;
      write_mode(1'b0);
      test_random_tensors(10);
      write_mode(1'b1);
      test_random_tensors(10);

      wait_drained();
      if (mismatch_count == 0 && pending_codes.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### minmax_affine_quantizer_top.f
+incdir+rtl
rtl/maq_pkg.sv
rtl/maq_front.sv
rtl/maq_queue.sv
rtl/maq_back.sv
rtl/minmax_affine_quantizer_top.sv
rtl/maq_checker.sv
dv/tb_minmax_affine_quantizer_top.sv
